// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on the house clock and reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(name, cond, msg) \
  `ASSERT_CLK(name, !(cond), msg)

`endif

// File: rtl/core/mdwp_pkg.sv
package mdwp_pkg;

  localparam int DEPTH_W     = 16;
  localparam int LABEL_W     = 16;
  localparam int MASK_W      = 8;
  localparam int INV_W       = 24;
  localparam int CENTER_W    = 16;
  localparam int COEF_W      = 32;
  localparam int COEF_IDX_W  = 4;
  localparam int WORLD_W     = 32;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;
  localparam int SUBPIX_BITS = 4;   // pixel positions in 1/16 pixel
  localparam int RND_SHIFT   = 30;  // Q2.30 scaling
  localparam int ROT_DIM     = 3;
  localparam int NUM_COEFS   = 12;
  localparam int TRANS_BASE  = 9;

  localparam logic [INV_W-1:0]    INV_FOCAL_RST = 24'd1789570;
  localparam logic [CENTER_W-1:0] CENTER_X_RST  = 16'd5120;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 16'd3840;
  localparam logic [DEPTH_W-1:0]  MIN_DEPTH_RST = 16'd300;
  localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RST = 16'd3000;
  localparam logic signed [COEF_W-1:0] ONE_Q30  = 32'sh4000_0000;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_LOAD  = 1'b1
  } item_mode_e;

  typedef enum logic [2:0] {
    REG_INV_FOCAL_X = 3'd0,
    REG_INV_FOCAL_Y = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_MIN_DEPTH   = 3'd4,
    REG_MAX_DEPTH   = 3'd5
  } cfg_reg_e;

endpackage

// File: rtl/core/mdwp_front.sv
module mdwp_front #(
  parameter int PIXEL_INDEX_BITS = 12,
  parameter int DU_W             = 17,
  parameter int ENTRY_W          = 2 * DU_W + 33
) (
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [PIXEL_INDEX_BITS-1:0]     column_i,
  input  logic [PIXEL_INDEX_BITS-1:0]     row_i,
  input  logic [mdwp_pkg::DEPTH_W-1:0]    depth_mm_i,
  input  logic [mdwp_pkg::MASK_W-1:0]     mask_value_i,
  input  logic [mdwp_pkg::LABEL_W-1:0]    label_i,
  input  logic [mdwp_pkg::COEF_IDX_W-1:0] coef_index_i,
  input  logic signed [mdwp_pkg::COEF_W-1:0] coef_value_i,
  input  logic [mdwp_pkg::CENTER_W-1:0]   center_x_i,
  input  logic [mdwp_pkg::CENTER_W-1:0]   center_y_i,
  input  logic [mdwp_pkg::DEPTH_W-1:0]    min_depth_i,
  input  logic [mdwp_pkg::DEPTH_W-1:0]    max_depth_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output logic [ENTRY_W-1:0]              push_data_o
);
  import mdwp_pkg::*;

  localparam int PAD_W = ENTRY_W - 1 - COEF_IDX_W - COEF_W;

  logic                   is_load;
  logic                   keep;
  logic signed [DU_W-1:0] du;
  logic signed [DU_W-1:0] dv;

  always_comb begin
    is_load = (mode_i == MODE_LOAD);
    if (is_load) begin
      keep = (coef_index_i < COEF_IDX_W'(NUM_COEFS));
    end else begin
      keep = (mask_value_i != '0) && (depth_mm_i >= min_depth_i) &&
             (depth_mm_i <= max_depth_i);
    end
    // offsets from the principal point, 1/16 pixel
    du = $signed(DU_W'({column_i, {SUBPIX_BITS{1'b0}}})) - $signed(DU_W'(center_x_i));
    dv = $signed(DU_W'({row_i, {SUBPIX_BITS{1'b0}}})) - $signed(DU_W'(center_y_i));
    if (is_load) begin
      push_data_o = {1'b1, {PAD_W{1'b0}}, coef_index_i, coef_value_i};
    end else begin
      push_data_o = {1'b0, du, dv, depth_mm_i, label_i};
    end
    push_o     = in_valid_i && !q_full_i && keep;
    in_stall_o = q_full_i;
  end

endmodule

// File: rtl/core/mdwp_queue.sv
`include "assert_macros.svh"

module mdwp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);
  import mdwp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  `ASSERT_NEVER(a_q_overflow, push_i && count_q == CNT_W'(DEPTH), "queue push while full")
  `ASSERT_NEVER(a_q_underflow, pop_i && count_q == '0, "queue pop while empty")
  `ASSERT_CLK(a_q_count_up, push_i && !pop_i |=> count_q == $past(count_q) + CNT_W'(1), "queue count did not follow push")

endmodule

// File: rtl/core/mdwp_back.sv
`include "assert_macros.svh"

module mdwp_back #(
  parameter int DU_W    = 17,
  parameter int ENTRY_W = 2 * DU_W + 33
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  logic [ENTRY_W-1:0]                q_data_i,
  output logic                              q_pop_o,
  input  logic [mdwp_pkg::INV_W-1:0]        inv_focal_x_i,
  input  logic [mdwp_pkg::INV_W-1:0]        inv_focal_y_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [mdwp_pkg::WORLD_W-1:0] world_x_o,
  output logic signed [mdwp_pkg::WORLD_W-1:0] world_y_o,
  output logic signed [mdwp_pkg::WORLD_W-1:0] world_z_o,
  output logic [mdwp_pkg::LABEL_W-1:0]      point_label_o
);
  import mdwp_pkg::*;

  localparam int PD_W   = DU_W + DEPTH_W + 1;     // depth * offset
  localparam int PX_W   = PD_W + INV_W + 1;       // * reciprocal focal length
  localparam int CAM_W  = 32;
  localparam int Z_W    = DEPTH_W + SUBPIX_BITS;
  localparam int ACC_W  = 64;
  localparam int SH_W   = ACC_W - RND_SHIFT;
  localparam int SUM_W  = SH_W + 1;
  localparam logic signed [PX_W-1:0]  PX_HALF  = PX_W'(1) << (RND_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (RND_SHIFT - 1);

  function automatic logic signed [WORLD_W-1:0] sat_world(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-WORLD_W:0] top;
    top = v[SUM_W-1:WORLD_W-1];
    if (top == '0 || top == '1) begin
      return v[WORLD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(WORLD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORLD_W-1){1'b1}}};
    end
  endfunction

  // queue head
  logic                          hd_load;
  logic [COEF_IDX_W-1:0]         hd_idx;
  logic signed [COEF_W-1:0]      hd_val;
  logic signed [DU_W-1:0]        hd_du, hd_dv;
  logic [DEPTH_W-1:0]            hd_depth;
  logic [LABEL_W-1:0]            hd_label;

  logic                          adv;
  logic                          pop_pix, pop_load;
  logic [5:1]                    v_q;

  logic signed [COEF_W-1:0]      tr_q [NUM_COEFS];

  logic signed [PD_W-1:0]        pd_x_q, pd_y_q;
  logic [Z_W-1:0]                z1_q, z2_q;
  logic signed [PX_W-1:0]        px_x_q, px_y_q;
  logic signed [PX_W-1:0]        rx, ry;
  logic signed [CAM_W-1:0]       cam_q [ROT_DIM];
  logic signed [ACC_W-1:0]       prod_q [ROT_DIM][ROT_DIM];
  logic signed [ACC_W-1:0]       acc_q [ROT_DIM];
  logic [LABEL_W-1:0]            lab_q [5:1];
  logic signed [WORLD_W-1:0]     world_q [ROT_DIM];
  logic [LABEL_W-1:0]            out_label_q;
  logic                          out_valid_q;

  assign hd_load  = q_data_i[ENTRY_W-1];
  assign hd_idx   = q_data_i[COEF_W +: COEF_IDX_W];
  assign hd_val   = q_data_i[COEF_W-1:0];
  assign hd_label = q_data_i[LABEL_W-1:0];
  assign hd_depth = q_data_i[LABEL_W +: DEPTH_W];
  assign hd_dv    = q_data_i[LABEL_W + DEPTH_W +: DU_W];
  assign hd_du    = q_data_i[LABEL_W + DEPTH_W + DU_W +: DU_W];

  // One enable moves the whole pipe; a load leaves the queue only once
  // every pixel ahead of it has gone through the transform.
  always_comb begin
    adv      = !out_valid_q || !out_stall_i;
    pop_pix  = q_valid_i && !hd_load && adv;
    pop_load = q_valid_i && hd_load && (v_q == '0);
    q_pop_o  = pop_pix || pop_load;
    rx       = px_x_q + PX_HALF;
    ry       = px_y_q + PX_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        tr_q[i] <= ((i % (ROT_DIM + 1) == 0) && (i < ROT_DIM * ROT_DIM)) ? ONE_Q30 : '0;
      end
    end else if (pop_load) begin
      tr_q[hd_idx] <= hd_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[4:1], pop_pix};
      out_valid_q <= v_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // s1: depth times offset
      pd_x_q   <= $signed({1'b0, hd_depth}) * hd_du;
      pd_y_q   <= $signed({1'b0, hd_depth}) * hd_dv;
      z1_q     <= {hd_depth, {SUBPIX_BITS{1'b0}}};
      lab_q[1] <= hd_label;
      // s2: scale by 1/f
      px_x_q   <= pd_x_q * $signed({1'b0, inv_focal_x_i});
      px_y_q   <= pd_y_q * $signed({1'b0, inv_focal_y_i});
      z2_q     <= z1_q;
      lab_q[2] <= lab_q[1];
      // s3: round to camera point, 1/16 mm
      cam_q[0] <= CAM_W'(rx >>> RND_SHIFT);
      cam_q[1] <= CAM_W'(ry >>> RND_SHIFT);
      cam_q[2] <= $signed(CAM_W'(z2_q));
      lab_q[3] <= lab_q[2];
      // s4: rotation products
      for (int i = 0; i < ROT_DIM; i++) begin
        for (int j = 0; j < ROT_DIM; j++) begin
          prod_q[i][j] <= tr_q[ROT_DIM * i + j] * cam_q[j];
        end
      end
      lab_q[4] <= lab_q[3];
      // s5: row sums with rounding bias
      for (int i = 0; i < ROT_DIM; i++) begin
        acc_q[i] <= prod_q[i][0] + prod_q[i][1] + prod_q[i][2] + ACC_HALF;
      end
      lab_q[5] <= lab_q[4];
      // s6: scale back, translate, saturate
      for (int i = 0; i < ROT_DIM; i++) begin
        world_q[i] <= sat_world(SUM_W'(SH_W'(acc_q[i] >>> RND_SHIFT)) +
                                SUM_W'(tr_q[TRANS_BASE + i]));
      end
      out_label_q <= lab_q[5];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign world_x_o     = world_q[0];
  assign world_y_o     = world_q[1];
  assign world_z_o     = world_q[2];
  assign point_label_o = out_label_q;

  `ASSERT_CLK(a_pipe_holds, v_q[5] && !adv |=> v_q[5], "pixel lost from last stage under stall")
  `ASSERT_CLK(a_out_from_pipe, $rose(out_valid_q) |-> $past(v_q[5]), "result without a pixel in the pipe")
  `ASSERT_CLK(a_load_bubble, pop_load |=> !v_q[1], "pixel entered alongside a transform load")

endmodule

// File: rtl/core/masked_depth_to_world_points_core.sv
// Channel   Dir  Handshake               Transfer carries
// in        in   in_valid_i / in_stall_o  mode, pixel fields or one transform word
// out       out  out_valid_o / out_stall_i  world x/y/z and point label
// cfg       in   psel/penable/pwrite      six camera and depth-limit registers
//
// Sustained rate is one pixel per cycle while the output is not stalled. A pixel
// result passes the input queue, then six pipeline stages ending in the output
// register. A transform load waits at the queue head until the pixels ahead of it
// have passed the translation stage.
// Input stalls only while the 4-entry queue is full; output stall freezes the pipe.
// Reset restores register defaults and the identity transform; no clearing pass.
module masked_depth_to_world_points_core #(
  parameter int PIXEL_INDEX_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 mode_i,
  input  logic [PIXEL_INDEX_BITS-1:0]          column_i,
  input  logic [PIXEL_INDEX_BITS-1:0]          row_i,
  input  logic [mdwp_pkg::DEPTH_W-1:0]         depth_mm_i,
  input  logic [mdwp_pkg::MASK_W-1:0]          mask_value_i,
  input  logic [mdwp_pkg::LABEL_W-1:0]         label_i,
  input  logic [mdwp_pkg::COEF_IDX_W-1:0]      coef_index_i,
  input  logic signed [mdwp_pkg::COEF_W-1:0]   coef_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mdwp_pkg::WORLD_W-1:0]  world_x_o,
  output logic signed [mdwp_pkg::WORLD_W-1:0]  world_y_o,
  output logic signed [mdwp_pkg::WORLD_W-1:0]  world_z_o,
  output logic [mdwp_pkg::LABEL_W-1:0]         point_label_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mdwp_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mdwp_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mdwp_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import mdwp_pkg::*;

  localparam int POS_W       = PIXEL_INDEX_BITS + SUBPIX_BITS;
  localparam int DU_W        = ((POS_W > CENTER_W) ? POS_W : CENTER_W) + 1;
  localparam int ENTRY_W     = 2 * DU_W + DEPTH_W + LABEL_W + 1;
  localparam int QUEUE_DEPTH = 4;

  logic [INV_W-1:0]    inv_focal_x_q, inv_focal_y_q;
  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [DEPTH_W-1:0]  min_depth_q, max_depth_q;
  logic                cfg_we;
  cfg_reg_e            cfg_sel;

  logic                q_full, q_push, q_pop, q_valid;
  logic [ENTRY_W-1:0]  q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_focal_x_q <= INV_FOCAL_RST;
      inv_focal_y_q <= INV_FOCAL_RST;
      center_x_q    <= CENTER_X_RST;
      center_y_q    <= CENTER_Y_RST;
      min_depth_q   <= MIN_DEPTH_RST;
      max_depth_q   <= MAX_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_INV_FOCAL_X: inv_focal_x_q <= pwdata[INV_W-1:0];
        REG_INV_FOCAL_Y: inv_focal_y_q <= pwdata[INV_W-1:0];
        REG_CENTER_X:    center_x_q    <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:    center_y_q    <= pwdata[CENTER_W-1:0];
        REG_MIN_DEPTH:   min_depth_q   <= pwdata[DEPTH_W-1:0];
        REG_MAX_DEPTH:   max_depth_q   <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_INV_FOCAL_X: prdata = APB_DATA_W'(inv_focal_x_q);
      REG_INV_FOCAL_Y: prdata = APB_DATA_W'(inv_focal_y_q);
      REG_CENTER_X:    prdata = APB_DATA_W'(center_x_q);
      REG_CENTER_Y:    prdata = APB_DATA_W'(center_y_q);
      REG_MIN_DEPTH:   prdata = APB_DATA_W'(min_depth_q);
      REG_MAX_DEPTH:   prdata = APB_DATA_W'(max_depth_q);
      default:         prdata = '0;
    endcase
  end

  mdwp_front #(
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS),
    .DU_W            (DU_W),
    .ENTRY_W         (ENTRY_W)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .depth_mm_i  (depth_mm_i),
    .mask_value_i(mask_value_i),
    .label_i     (label_i),
    .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .min_depth_i (min_depth_q),
    .max_depth_i (max_depth_q),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  mdwp_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata),
    .full_o (q_full)
  );

  mdwp_back #(
    .DU_W   (DU_W),
    .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .inv_focal_x_i(inv_focal_x_q),
    .inv_focal_y_i(inv_focal_y_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .world_x_o    (world_x_o),
    .world_y_o    (world_y_o),
    .world_z_o    (world_z_o),
    .point_label_o(point_label_o)
  );

endmodule
